[rtl/mcfe_pkg.sv]
package mcfe_pkg;

   localparam int POS_CODE_BITS   = 16;
   localparam int FIELD_CODE_BITS = 12;
   localparam int FRAC_BITS       = 16;
   localparam int TOTAL_BITS      = POS_CODE_BITS + 4 * FIELD_CODE_BITS;
   localparam int DIV_STEPS       = (POS_CODE_BITS > FIELD_CODE_BITS) ?
                                    POS_CODE_BITS : FIELD_CODE_BITS;
   localparam int LANES           = 5;
   localparam int VAL_W           = 32;
   localparam int LIMIT_W         = 31;
   localparam int NUM_W           = VAL_W + DIV_STEPS;
   localparam int ID_W            = 11;
   localparam int ACTION_W        = 3;
   localparam int CSR_INDEX_W     = 3;

   // lane order inside a frame
   localparam int LANE_POS   = 0;
   localparam int LANE_SPEED = 1;
   localparam int LANE_KP    = 2;
   localparam int LANE_KD    = 3;
   localparam int LANE_TORQ  = 4;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_CONTROL  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ENABLE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_DISABLE  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SET_ZERO = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PASSIVE  = 3'd4;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_POSITION_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LIMIT    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TORQUE_LIMIT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STIFFNESS_MAX  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING_MAX    = 3'd4;

   localparam logic [LIMIT_W-1:0] RST_POSITION_LIMIT = 31'd819200;
   localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT    = 31'd1966080;
   localparam logic [LIMIT_W-1:0] RST_TORQUE_LIMIT   = 31'd655360;
   localparam logic [LIMIT_W-1:0] RST_STIFFNESS_MAX  = 31'd32768000;
   localparam logic [LIMIT_W-1:0] RST_DAMPING_MAX    = 31'd327680;

   localparam logic [7:0] FILL_BYTE    = 8'hFF;
   localparam logic [7:0] TAIL_ENABLE  = 8'hFC;
   localparam logic [7:0] TAIL_DISABLE = 8'hFD;
   localparam logic [7:0] TAIL_ZERO    = 8'hFE;
   localparam logic [VAL_W-1:0] PASSIVE_KD = VAL_W'(2) << FRAC_BITS;

   typedef struct packed {
      logic [ID_W-1:0]             frame_id;
      logic                        frame_channel;
      logic                        special;
      logic [7:0]                  tail;
      logic [LANES-1:0][VAL_W-1:0] offset;
   } entry_type;

   typedef struct packed {
      logic [LANES-1:0][VAL_W-1:0] span;
   } span_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] position_limit;
      logic [LIMIT_W-1:0] speed_limit;
      logic [LIMIT_W-1:0] torque_limit;
      logic [LIMIT_W-1:0] stiffness_max;
      logic [LIMIT_W-1:0] damping_max;
   } limits_type;

   function automatic int lane_bits(input int lane);
      return (lane == LANE_POS) ? POS_CODE_BITS : FIELD_CODE_BITS;
   endfunction

endpackage

[rtl/mcfe_front.sv]
module mcfe_front (
   input  logic [mcfe_pkg::ACTION_W-1:0] req_action,
   input  logic [mcfe_pkg::ID_W-1:0]     req_motor_id,
   input  logic                          req_bus_channel,
   input  logic signed [31:0]            req_target_position,
   input  logic signed [31:0]            req_target_speed,
   input  logic signed [31:0]            req_stiffness,
   input  logic signed [31:0]            req_damping,
   input  logic signed [31:0]            req_feedforward_torque,
   input  mcfe_pkg::limits_type          limits,
   output mcfe_pkg::entry_type           entry
);
   import mcfe_pkg::*;

   // offset of x clamped to [-lim, lim], measured from -lim
   function automatic logic [VAL_W-1:0] sym_offset(input logic signed [31:0] x,
                                                   input logic [LIMIT_W-1:0] lim);
      logic signed [33:0] hi;
      logic signed [33:0] xs;
      logic signed [33:0] sum;
      hi = signed'({3'b000, lim});
      xs = 34'(x);
      if (xs > hi) begin
         xs = hi;
      end else if (xs < -hi) begin
         xs = -hi;
      end
      sum = xs + hi;
      return sum[VAL_W-1:0];
   endfunction

   // x clamped to [0, max]
   function automatic logic [VAL_W-1:0] gain_offset(input logic signed [31:0] x,
                                                    input logic [LIMIT_W-1:0] mx);
      logic [VAL_W-1:0] res;
      if (x < 0) begin
         res = '0;
      end else if (x > signed'({1'b0, mx})) begin
         res = {1'b0, mx};
      end else begin
         res = x;
      end
      return res;
   endfunction

   logic              passive;
   logic signed [31:0] spd;
   logic signed [31:0] kp;
   logic signed [31:0] kd;
   logic signed [31:0] tq;

   // classify the action and override set-points for passive damping
   always_comb begin
      passive = (req_action == ACT_PASSIVE);
      spd = passive ? '0 : req_target_speed;
      kp  = passive ? '0 : req_stiffness;
      kd  = passive ? signed'(PASSIVE_KD) : req_damping;
      tq  = passive ? '0 : req_feedforward_torque;

      entry.frame_id      = req_motor_id;
      entry.frame_channel = req_bus_channel;
      entry.special       = 1'b0;
      entry.tail          = TAIL_ENABLE;
      unique case (req_action)
         ACT_ENABLE: begin
            entry.special = 1'b1;
            entry.tail    = TAIL_ENABLE;
         end
         ACT_DISABLE: begin
            entry.special = 1'b1;
            entry.tail    = TAIL_DISABLE;
         end
         ACT_SET_ZERO: begin
            entry.special = 1'b1;
            entry.tail    = TAIL_ZERO;
         end
         default: begin
            entry.special = 1'b0;
         end
      endcase

      entry.offset[LANE_POS]   = sym_offset(req_target_position, limits.position_limit);
      entry.offset[LANE_SPEED] = sym_offset(spd, limits.speed_limit);
      entry.offset[LANE_KP]    = gain_offset(kp, limits.stiffness_max);
      entry.offset[LANE_KD]    = gain_offset(kd, limits.damping_max);
      entry.offset[LANE_TORQ]  = sym_offset(tq, limits.torque_limit);
   end

endmodule

[rtl/mcfe_queue.sv]
module mcfe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mcfe_pkg::entry_type push_entry,
   input  logic                pop,
   output mcfe_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import mcfe_pkg::*;

   entry_type   slot_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      empty     = (count_ff == 2'd0);
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // advance pointers and store the incoming beat
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("queue pop while empty");
`endif

endmodule

[rtl/mcfe_back.sv]
module mcfe_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mcfe_pkg::entry_type     head,
   input  logic                    empty,
   output logic                    pop,
   input  mcfe_pkg::span_type      spans,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [mcfe_pkg::ID_W-1:0] rsp_frame_id,
   output logic                    rsp_frame_channel,
   output logic [63:0]             rsp_frame_data
);
   import mcfe_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] frame_id;
      logic            frame_channel;
      logic            special;
      logic [7:0]      tail;
   } meta_type;

   logic                             move;
   logic [DIV_STEPS:0]               valid_ff;
   meta_type                         meta_ff [DIV_STEPS+1];
   logic [LANES-1:0][VAL_W-1:0]      rem_ff  [DIV_STEPS+1];
   logic [LANES-1:0][DIV_STEPS-1:0]  low_ff  [DIV_STEPS+1];
   logic [LANES-1:0][DIV_STEPS-1:0]  quo_ff  [DIV_STEPS+1];
   logic [LANES-1:0][VAL_W-1:0]      rem_in  [DIV_STEPS+1];
   logic [LANES-1:0][DIV_STEPS-1:0]  low_in  [DIV_STEPS+1];
   logic [LANES-1:0][DIV_STEPS-1:0]  quo_in  [DIV_STEPS+1];
   logic [NUM_W-1:0]                 num;
   logic [VAL_W:0]                   trial;
   logic                             ge;
   logic [TOTAL_BITS-1:0]            codes;
   logic [63:0]                      data_in;
   logic                             rsp_valid_ff;
   logic [ID_W-1:0]                  rsp_frame_id_ff;
   logic                             rsp_frame_channel_ff;
   logic [63:0]                      rsp_frame_data_ff;

   // the whole pipe advances whenever the output register can take a beat
   assign move = !rsp_valid_ff || !rsp_stall;
   assign pop  = move && !empty;

   always_comb begin
      // load: scale offset by 2^bits - 1, split into start remainder and low bits
      for (int l = 0; l < LANES; l++) begin
         num = (NUM_W'(head.offset[l]) << lane_bits(l)) - NUM_W'(head.offset[l]);
         rem_in[0][l] = num[NUM_W-1:DIV_STEPS];
         low_in[0][l] = num[DIV_STEPS-1:0];
         quo_in[0][l] = '0;
      end
      // one restoring division step per stage
      for (int k = 1; k <= DIV_STEPS; k++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_ff[k-1][l], low_ff[k-1][l][DIV_STEPS-1]};
            ge    = (trial >= {1'b0, spans.span[l]});
            rem_in[k][l] = ge ? VAL_W'(trial - {1'b0, spans.span[l]}) : trial[VAL_W-1:0];
            low_in[k][l] = {low_ff[k-1][l][DIV_STEPS-2:0], 1'b0};
            quo_in[k][l] = {quo_ff[k-1][l][DIV_STEPS-2:0], ge};
         end
      end
      // pack codes big-endian, zero span gives code zero
      codes = '0;
      for (int l = 0; l < LANES; l++) begin
         codes = codes << lane_bits(l);
         if (spans.span[l] != '0) begin
            codes = codes | TOTAL_BITS'(quo_ff[DIV_STEPS][l] &
                                        ((DIV_STEPS'(1) << lane_bits(l)) - DIV_STEPS'(1)));
         end
      end
      if (meta_ff[DIV_STEPS].special) begin
         data_in = {{7{FILL_BYTE}}, meta_ff[DIV_STEPS].tail};
      end else begin
         data_in = 64'(codes) << (64 - TOTAL_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         valid_ff     <= {valid_ff[DIV_STEPS-1:0], !empty};
         rsp_valid_ff <= valid_ff[DIV_STEPS];
      end
      // advance payload
      if (move) begin
         meta_ff[0] <= '{frame_id: head.frame_id, frame_channel: head.frame_channel,
                         special: head.special, tail: head.tail};
         for (int k = 0; k <= DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
         end
         for (int k = 1; k <= DIV_STEPS; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
         rsp_frame_id_ff      <= meta_ff[DIV_STEPS].frame_id;
         rsp_frame_channel_ff <= meta_ff[DIV_STEPS].frame_channel;
         rsp_frame_data_ff    <= data_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_id      = rsp_frame_id_ff;
   assign rsp_frame_channel = rsp_frame_channel_ff;
   assign rsp_frame_data    = rsp_frame_data_ff;

`ifndef SYNTHESIS
   a_last_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_STEPS] && move) |=> rsp_valid)
      else $error("finished beat did not reach output");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(valid_ff)))
      else $error("pipe moved under stall");
`endif

endmodule

[rtl/motor_command_frame_encoder_unit.sv]
// channel | direction | handshake           | payload
// req     | in        | req_valid/req_stall | action, ids, five Q15.16 set-points
// rsp     | out       | rsp_valid/rsp_stall | frame id, channel, 64-bit data
// csr     | in        | csr_write_enable    | index, 31-bit data
// One beat per cycle while rsp is not stalled; a beat passes the queue write,
// load stage, one pipelined divider stage per widest-code bit, output register.
// Reset is synchronous, clears valid state and loads the limit registers' defaults.
// A stalled rsp beat freezes the back pipe; the 2-entry queue stalls req once full.
module motor_command_frame_encoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mcfe_pkg::ACTION_W-1:0]    req_action,
   input  logic [mcfe_pkg::ID_W-1:0]        req_motor_id,
   input  logic                             req_bus_channel,
   input  logic signed [31:0]               req_target_position,
   input  logic signed [31:0]               req_target_speed,
   input  logic signed [31:0]               req_stiffness,
   input  logic signed [31:0]               req_damping,
   input  logic signed [31:0]               req_feedforward_torque,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mcfe_pkg::ID_W-1:0]        rsp_frame_id,
   output logic                             rsp_frame_channel,
   output logic [63:0]                      rsp_frame_data,
   input  logic                             csr_write_enable,
   input  logic [mcfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mcfe_pkg::LIMIT_W-1:0]     csr_write_data
);
   import mcfe_pkg::*;

   limits_type limits_ff;
   limits_type limits_in;
   span_type   spans;
   entry_type  entry;
   entry_type  head;
   logic       full;
   logic       empty;
   logic       pop;
   logic       push;

   // register writes
   always_comb begin
      limits_in = limits_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POSITION_LIMIT: limits_in.position_limit = csr_write_data;
            CSR_SPEED_LIMIT:    limits_in.speed_limit    = csr_write_data;
            CSR_TORQUE_LIMIT:   limits_in.torque_limit   = csr_write_data;
            CSR_STIFFNESS_MAX:  limits_in.stiffness_max  = csr_write_data;
            CSR_DAMPING_MAX:    limits_in.damping_max    = csr_write_data;
            default:            limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{position_limit: RST_POSITION_LIMIT, speed_limit: RST_SPEED_LIMIT,
                        torque_limit: RST_TORQUE_LIMIT, stiffness_max: RST_STIFFNESS_MAX,
                        damping_max: RST_DAMPING_MAX};
      end else begin
         limits_ff <= limits_in;
      end
   end

   // quantizer spans per lane
   always_comb begin
      spans.span[LANE_POS]   = {limits_ff.position_limit, 1'b0};
      spans.span[LANE_SPEED] = {limits_ff.speed_limit, 1'b0};
      spans.span[LANE_KP]    = {1'b0, limits_ff.stiffness_max};
      spans.span[LANE_KD]    = {1'b0, limits_ff.damping_max};
      spans.span[LANE_TORQ]  = {limits_ff.torque_limit, 1'b0};
   end

   assign req_stall = full;
   assign push      = req_valid && !full;

   mcfe_front u_front (
      .req_action             (req_action),
      .req_motor_id           (req_motor_id),
      .req_bus_channel        (req_bus_channel),
      .req_target_position    (req_target_position),
      .req_target_speed       (req_target_speed),
      .req_stiffness          (req_stiffness),
      .req_damping            (req_damping),
      .req_feedforward_torque (req_feedforward_torque),
      .limits                 (limits_ff),
      .entry                  (entry)
   );

   mcfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .empty      (empty)
   );

   mcfe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .empty             (empty),
      .pop               (pop),
      .spans             (spans),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_frame_channel (rsp_frame_channel),
      .rsp_frame_data    (rsp_frame_data)
   );

endmodule

[bench/tb_motor_command_frame_encoder_unit.sv]
`timescale 1ns / 100ps

module tb_motor_command_frame_encoder_unit;
   import mcfe_pkg::*;

   localparam int DRAIN_CYCLES = DIV_STEPS + 12;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ID_W-1:0]     motor_id;
      logic                bus_channel;
      logic [31:0]         position;
      logic [31:0]         speed;
      logic [31:0]         kp;
      logic [31:0]         kd;
      logic [31:0]         torque;
   } command_type;

   typedef struct packed {
      logic [ID_W-1:0] frame_id;
      logic            frame_channel;
      logic [63:0]     frame_data;
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [ID_W-1:0] req_motor_id = '0;
   logic req_bus_channel = 1'b0;
   logic signed [31:0] req_target_position = '0;
   logic signed [31:0] req_target_speed = '0;
   logic signed [31:0] req_stiffness = '0;
   logic signed [31:0] req_damping = '0;
   logic signed [31:0] req_feedforward_torque = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [ID_W-1:0] rsp_frame_id;
   logic rsp_frame_channel;
   logic [63:0] rsp_frame_data;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [LIMIT_W-1:0] csr_write_data = '0;

   motor_command_frame_encoder_unit dut (.*);

   always #5 clock = ~clock;

   // predictor copy of the limit registers
   logic [LIMIT_W-1:0] lim_pos, lim_speed, lim_torque, max_kp, max_kd;

   command_type pending_cmds[$];
   frame_type   expected_frames[$];
   int  errors = 0;
   int  cycles = 0;
   bit  hold_off = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;
   logic accepted_q = 1'b0;

   function automatic logic [63:0] quantize_code(longint x, longint lo, longint hi,
                                                 int bits);
      longint unsigned full;
      if (hi <= lo) return 0;
      if (x > hi) x = hi;
      else if (x < lo) x = lo;
      full = (64'd1 << bits) - 1;
      return (longint'(x - lo) * full) / longint'(hi - lo);
   endfunction

   function automatic frame_type encode_frame(command_type c);
      frame_type f;
      longint p, s, kp, kd, t;
      f.frame_id = c.motor_id;
      f.frame_channel = c.bus_channel;
      case (c.action)
         ACT_ENABLE:   f.frame_data = {{7{FILL_BYTE}}, TAIL_ENABLE};
         ACT_DISABLE:  f.frame_data = {{7{FILL_BYTE}}, TAIL_DISABLE};
         ACT_SET_ZERO: f.frame_data = {{7{FILL_BYTE}}, TAIL_ZERO};
         default: begin
            p = longint'(signed'(c.position));
            s = longint'(signed'(c.speed));
            kp = longint'(signed'(c.kp));
            kd = longint'(signed'(c.kd));
            t = longint'(signed'(c.torque));
            if (c.action == ACT_PASSIVE) begin
               s = 0; kp = 0; t = 0;
               kd = longint'(2) << FRAC_BITS;
            end
            f.frame_data = quantize_code(p, -longint'(lim_pos), longint'(lim_pos),
                                         POS_CODE_BITS);
            f.frame_data = (f.frame_data << FIELD_CODE_BITS) |
               quantize_code(s, -longint'(lim_speed), longint'(lim_speed), FIELD_CODE_BITS);
            f.frame_data = (f.frame_data << FIELD_CODE_BITS) |
               quantize_code(kp, 0, longint'(max_kp), FIELD_CODE_BITS);
            f.frame_data = (f.frame_data << FIELD_CODE_BITS) |
               quantize_code(kd, 0, longint'(max_kd), FIELD_CODE_BITS);
            f.frame_data = (f.frame_data << FIELD_CODE_BITS) |
               quantize_code(t, -longint'(lim_torque), longint'(lim_torque),
                             FIELD_CODE_BITS);
            if (TOTAL_BITS < 64) f.frame_data = f.frame_data << (64 - TOTAL_BITS);
         end
      endcase
      return f;
   endfunction

   // pick a set-point near the interesting region or fully random
   function automatic logic [31:0] pick_value(logic [LIMIT_W-1:0] limit);
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return {1'b0, limit} + $urandom_range(0, 3) - 1;
         2: return -{1'b0, limit} + $urandom_range(0, 3) - 1;
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return ($urandom % (2 * {1'b0, limit} + 3)) - {1'b0, limit} - 1;
      endcase
   endfunction

   function automatic command_type random_command();
      command_type c;
      int r;
      r = $urandom_range(0, 19);
      c.action = (r < 10) ? ACT_CONTROL : (r < 13) ? ACT_PASSIVE :
                 (r == 19) ? ACTION_W'($urandom_range(5, 7)) :
                 ACTION_W'($urandom_range(1, 3));
      c.motor_id = ID_W'($urandom);
      c.bus_channel = 1'($urandom);
      c.position = pick_value(lim_pos);
      c.speed = pick_value(lim_speed);
      c.kp = pick_value(max_kp);
      c.kd = pick_value(max_kd);
      c.torque = pick_value(lim_torque);
      return c;
   endfunction

   task automatic write_limit(logic [CSR_INDEX_W-1:0] idx, logic [LIMIT_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_POSITION_LIMIT: lim_pos = val;
         CSR_SPEED_LIMIT:    lim_speed = val;
         CSR_TORQUE_LIMIT:   lim_torque = val;
         CSR_STIFFNESS_MAX:  max_kp = val;
         default:            max_kd = val;
      endcase
   endtask

   task automatic set_limits(logic [LIMIT_W-1:0] p, logic [LIMIT_W-1:0] s,
                             logic [LIMIT_W-1:0] t, logic [LIMIT_W-1:0] kp,
                             logic [LIMIT_W-1:0] kd);
      write_limit(CSR_POSITION_LIMIT, p);
      write_limit(CSR_SPEED_LIMIT, s);
      write_limit(CSR_TORQUE_LIMIT, t);
      write_limit(CSR_STIFFNESS_MAX, kp);
      write_limit(CSR_DAMPING_MAX, kd);
   endtask

   // wait for every queued command to be sent and every frame to return
   task automatic drain();
      wait (pending_cmds.size() == 0 && expected_frames.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic add_command(logic [ACTION_W-1:0] a, logic [31:0] p, logic [31:0] s,
                              logic [31:0] kp, logic [31:0] kd, logic [31:0] t);
      command_type c;
      c.action = a; c.motor_id = ID_W'($urandom); c.bus_channel = 1'($urandom);
      c.position = p; c.speed = s; c.kp = kp; c.kd = kd; c.torque = t;
      pending_cmds.push_back(c);
   endtask

   // driver: bursts with random gaps, payload held while stalled
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || accepted_q) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               req_valid <= 1'b1;
               req_action <= pending_cmds[0].action;
               req_motor_id <= pending_cmds[0].motor_id;
               req_bus_channel <= pending_cmds[0].bus_channel;
               req_target_position <= pending_cmds[0].position;
               req_target_speed <= pending_cmds[0].speed;
               req_stiffness <= pending_cmds[0].kp;
               req_damping <= pending_cmds[0].kd;
               req_feedforward_torque <= pending_cmds[0].torque;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 20);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: sample both handshakes at the rising edge
   always @(posedge clock) begin
      frame_type exp_f;
      command_type c;
      cycles <= cycles + 1;
      accepted_q <= 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            c = pending_cmds.pop_front();
            expected_frames.push_back(encode_frame(c));
            accepted_q <= 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected frame id=%h ch=%b data=%h", $time,
                        rsp_frame_id, rsp_frame_channel, rsp_frame_data);
               errors++;
            end else begin
               exp_f = expected_frames.pop_front();
               if (rsp_frame_id !== exp_f.frame_id) begin
                  $display("%0t: frame_id expected %h actual %h", $time,
                           exp_f.frame_id, rsp_frame_id);
                  errors++;
               end
               if (rsp_frame_channel !== exp_f.frame_channel) begin
                  $display("%0t: frame_channel expected %b actual %b", $time,
                           exp_f.frame_channel, rsp_frame_channel);
                  errors++;
               end
               if (rsp_frame_data !== exp_f.frame_data) begin
                  $display("%0t: frame_data expected %h actual %h", $time,
                           exp_f.frame_data, rsp_frame_data);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stall pattern, with a long hold-off when requested
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else if (cycles % 400 < 150) rsp_stall <= 1'b0;
      else rsp_stall <= (r < 35);
   end

   // timeout guard
   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      lim_pos = RST_POSITION_LIMIT; lim_speed = RST_SPEED_LIMIT;
      lim_torque = RST_TORQUE_LIMIT; max_kp = RST_STIFFNESS_MAX;
      max_kd = RST_DAMPING_MAX;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every action, field extremes, passive and unknown codes
      add_command(ACT_CONTROL, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
      add_command(ACT_CONTROL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_command(ACT_CONTROL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000);
      add_command(ACT_CONTROL, 819200, 1966080, 32768000, 327680, 655360);
      add_command(ACT_CONTROL, -819200, -1966080, 0, 0, -655360);
      add_command(ACT_CONTROL, 819199, -1966079, 1, 327679, 1);
      add_command(ACT_ENABLE, 32'hFFFF_FFFF, 0, 0, 0, 0);
      add_command(ACT_DISABLE, 0, 32'hFFFF_FFFF, 0, 0, 0);
      add_command(ACT_SET_ZERO, 0, 0, 32'hFFFF_FFFF, 0, 0);
      add_command(ACT_PASSIVE, 12345, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000);
      add_command(ACT_PASSIVE, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0);
      add_command(3'd5, 100, -100, 5000, 5000, 7);
      add_command(3'd6, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1);
      add_command(3'd7, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, -1);
      drain();

      // passive kd saturates against a small damping range
      set_limits(31'd1, 31'd1, 31'd1, 31'd1, 31'd1);
      add_command(ACT_PASSIVE, 1, 0, 0, 0, 0);
      add_command(ACT_CONTROL, -1, 1, 1, 0, 0);
      add_command(ACT_CONTROL, 0, 0, 0, 1, -2);
      drain();

      // random phases over several limit settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_limits(RST_POSITION_LIMIT, RST_SPEED_LIMIT, RST_TORQUE_LIMIT,
                          RST_STIFFNESS_MAX, RST_DAMPING_MAX);
            1: set_limits({LIMIT_W{1'b1}}, {LIMIT_W{1'b1}}, {LIMIT_W{1'b1}},
                          {LIMIT_W{1'b1}}, {LIMIT_W{1'b1}});
            2: set_limits(31'd1, {LIMIT_W{1'b1}}, 31'd3, 31'd1, {LIMIT_W{1'b1}});
            default: set_limits(
               LIMIT_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30)),
               LIMIT_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24)),
               LIMIT_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24)),
               LIMIT_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24)),
               LIMIT_W'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24)));
         endcase
         // hold the receiver off while the sender keeps offering beats
         if (phase == 3) begin
            hold_off = 1'b1;
            for (int i = 0; i < 30; i++) pending_cmds.push_back(random_command());
            repeat (200) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 150; i++) pending_cmds.push_back(random_command());
         drain();
      end

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
rtl/mcfe_pkg.sv
rtl/mcfe_front.sv
rtl/mcfe_queue.sv
rtl/mcfe_back.sv
rtl/motor_command_frame_encoder_unit.sv
bench/tb_motor_command_frame_encoder_unit.sv
